// ===== rtl/lru_pkg.sv =====
// ----------------------------------------------------------------------------
// lru_pkg : shared types and constants for the LRU page replacement block
// Controller states, controller/datapath command and status groups, register
// map codes.
// ----------------------------------------------------------------------------
package lru_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SEARCH,
		ST_UPDATE
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;    // capture the request and the active frame count
		logic look;    // match / free frame search, load the rank tree
		logic search;  // one level of the rank reduction
		logic update;  // write the frame table and the result registers
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic need_search;  // miss with no free frame: victim must be found
	} status_t;

	// register map
	localparam int unsigned REG_W              = 32;
	localparam logic        REG_FRAMES_IN_USE  = 1'b0;
	localparam int unsigned FIU_W              = 5;
	localparam logic [FIU_W-1:0] FIU_RESET     = 5'd16;

	// result fields
	localparam int unsigned PAGE_W   = 16;
	localparam int unsigned FIDX_W   = 4;
	localparam int unsigned FCNT_W   = 32;
	localparam logic [FCNT_W-1:0] FCNT_MAX = '1;

endpackage

// ===== rtl/lru_cfg.sv =====
// ----------------------------------------------------------------------------
// lru_cfg : configuration register file
// APB-style slave holding frames_in_use; writes complete in the access phase.
// ----------------------------------------------------------------------------
module lru_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [lru_pkg::REG_W-1:0]     pwdata,
	output logic [lru_pkg::REG_W-1:0]     prdata,
	output logic                          pready,
	output logic [lru_pkg::FIU_W-1:0]     frames_in_use
);

	logic [lru_pkg::FIU_W-1:0] fiu_q;
	logic                      wr_en;
	logic                      sel_fiu;

	// register i sits at byte address 4*i, so bit 2 carries the index
	assign sel_fiu = (paddr[2] == lru_pkg::REG_FRAMES_IN_USE);
	assign wr_en   = psel && penable && pwrite && sel_fiu;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q <= lru_pkg::FIU_RESET;
		end else if (wr_en) begin
			fiu_q <= pwdata[lru_pkg::FIU_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_fiu && paddr[1:0] == 2'b00) begin
			prdata = lru_pkg::REG_W'(fiu_q);
		end
	end

	assign frames_in_use = fiu_q;

endmodule

// ===== rtl/lru_ctrl.sv =====
// ----------------------------------------------------------------------------
// lru_ctrl : sequencing state machine
// Steps a request through lookup, the optional victim search and the table
// update, and raises the result strobe.
// ----------------------------------------------------------------------------
module lru_ctrl #(
	parameter int unsigned LEV = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  lru_pkg::status_t st,
	output lru_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             done
);

	localparam int unsigned CW = (LEV > 0) ? $clog2(LEV + 1) : 1;

	lru_pkg::state_t state_q, state_d;
	logic [CW-1:0]   lvl_q;
	logic            done_q;
	logic            last_lvl;

	assign last_lvl = (32'(lvl_q) + 32'd1 >= LEV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lru_pkg::ST_IDLE;
			lvl_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.update;
			if (cmd.look) begin
				lvl_q <= '0;
			end else if (cmd.search) begin
				lvl_q <= lvl_q + CW'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			lru_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = lru_pkg::ST_LOOK;
				end
			end
			lru_pkg::ST_LOOK: begin
				cmd.look = 1'b1;
				if (st.need_search && LEV > 0) begin
					state_d = lru_pkg::ST_SEARCH;
				end else begin
					state_d = lru_pkg::ST_UPDATE;
				end
			end
			lru_pkg::ST_SEARCH: begin
				cmd.search = 1'b1;
				if (last_lvl) begin
					state_d = lru_pkg::ST_UPDATE;
				end
			end
			lru_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = lru_pkg::ST_IDLE;
			end
			default: begin
				state_d = lru_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != lru_pkg::ST_IDLE);
	assign done = done_q;

	a_accept_to_look: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == lru_pkg::ST_LOOK)
		else $error("accepted request did not enter lookup");

	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> done && !busy)
		else $error("result strobe missing after table update");

	a_search_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lru_pkg::ST_SEARCH |-> 32'(lvl_q) < LEV)
		else $error("victim search ran past the last tree level");

endmodule

// ===== rtl/lru_dp.sv =====
// ----------------------------------------------------------------------------
// lru_dp : frame table and replacement datapath
// Frame pages, valid bits and recency ranks, hit / free frame encoders, a
// pairwise reduction tree for the victim and the rank update.
// ----------------------------------------------------------------------------
module lru_dp #(
	parameter int unsigned FRAMES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lru_pkg::cmd_t                 cmd,
	output lru_pkg::status_t              st,
	input  logic [lru_pkg::PAGE_W-1:0]    page_number,
	input  logic [lru_pkg::FIU_W-1:0]     frames_in_use,
	output logic                          fault,
	output logic [lru_pkg::FIDX_W-1:0]    frame_index,
	output logic                          evicted_valid,
	output logic [lru_pkg::PAGE_W-1:0]    evicted_page,
	output logic [lru_pkg::FCNT_W-1:0]    fault_total
);

	localparam int unsigned IW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int unsigned NW  = $clog2(FRAMES + 1);
	localparam int unsigned LEV = $clog2(FRAMES);
	localparam int unsigned P2  = 1 << LEV;
	localparam logic [IW-1:0] RMAX = IW'(FRAMES - 1);

	typedef struct packed {
		logic          cand;
		logic [IW-1:0] rank;
		logic [IW-1:0] idx;
	} node_t;

	logic [lru_pkg::PAGE_W-1:0] frame_page_q [FRAMES];
	logic [FRAMES-1:0]          frame_valid_q;
	logic [IW-1:0]              rank_q [FRAMES];
	node_t                      tree_q [P2];
	node_t                      tree_ld [P2];

	logic [lru_pkg::PAGE_W-1:0] req_page_q;
	logic [NW-1:0]              n_q;
	logic                       hit_q, fill_q;
	logic [IW-1:0]              hit_idx_q, free_idx_q;
	logic [lru_pkg::FCNT_W-1:0] fault_cnt_q;

	logic                       res_fault_q, res_ev_valid_q;
	logic [lru_pkg::FIDX_W-1:0] res_idx_q;
	logic [lru_pkg::PAGE_W-1:0] res_ev_page_q;

	logic [FRAMES-1:0] active, match, free;
	logic              any_hit, any_free;
	logic [IW-1:0]     hit_idx, free_idx;
	logic [IW-1:0]     k, old_rank;
	logic              evict;

	function automatic node_t better(input node_t a, input node_t b);
		// a holds the lower index, so it keeps ties
		if (b.cand && (!a.cand || b.rank > a.rank)) begin
			return b;
		end
		return a;
	endfunction

	// lookup: parallel compare, lowest index wins
	always_comb begin
		any_hit  = 1'b0;
		any_free = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int i = 0; i < FRAMES; i++) begin
			active[i] = (32'(i) < 32'(n_q));
			match[i]  = active[i] && frame_valid_q[i] && (frame_page_q[i] == req_page_q);
			free[i]   = active[i] && !frame_valid_q[i];
		end
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (match[i]) begin
				any_hit = 1'b1;
				hit_idx = IW'(i);
			end
			if (free[i]) begin
				any_free = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	assign st.need_search = !any_hit && !any_free;

	always_comb begin
		for (int i = 0; i < P2; i++) begin
			tree_ld[i] = '0;
		end
		for (int i = 0; i < FRAMES; i++) begin
			tree_ld[i].cand = active[i];
			tree_ld[i].rank = rank_q[i];
			tree_ld[i].idx  = IW'(i);
		end
	end

	// request capture, lookup results and victim tree
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_page_q <= page_number;
			if (frames_in_use == '0) begin
				n_q <= NW'(1);
			end else if (32'(frames_in_use) > FRAMES) begin
				n_q <= NW'(FRAMES);
			end else begin
				n_q <= NW'(frames_in_use);
			end
		end
		if (cmd.look) begin
			hit_q      <= any_hit;
			fill_q     <= !any_hit && any_free;
			hit_idx_q  <= hit_idx;
			free_idx_q <= free_idx;
			tree_q     <= tree_ld;
		end else if (cmd.search) begin
			for (int j = 0; j < P2 / 2; j++) begin
				tree_q[j] <= better(tree_q[2*j], tree_q[2*j+1]);
			end
		end
	end

	// on eviction the victim's own rank is the maximum, so rank_q[k] serves
	assign k        = hit_q ? hit_idx_q : (fill_q ? free_idx_q : tree_q[0].idx);
	assign old_rank = rank_q[k];
	assign evict    = !hit_q && !fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= '0;
			fault_cnt_q   <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cmd.update) begin
			for (int i = 0; i < FRAMES; i++) begin
				if (32'(i) == 32'(k)) begin
					rank_q[i] <= '0;
				end else if (active[i] && frame_valid_q[i] &&
				             (fill_q || rank_q[i] < old_rank) && rank_q[i] != RMAX) begin
					rank_q[i] <= rank_q[i] + IW'(1);
				end
			end
			frame_valid_q[k] <= 1'b1;
			if (!hit_q && fault_cnt_q != lru_pkg::FCNT_MAX) begin
				fault_cnt_q <= fault_cnt_q + lru_pkg::FCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			frame_page_q[k] <= req_page_q;
			res_fault_q     <= !hit_q;
			res_idx_q       <= lru_pkg::FIDX_W'(k);
			res_ev_valid_q  <= evict;
			res_ev_page_q   <= evict ? frame_page_q[k] : '0;
		end
	end

	assign fault         = res_fault_q;
	assign frame_index   = res_idx_q;
	assign evicted_valid = res_ev_valid_q;
	assign evicted_page  = res_ev_page_q;
	assign fault_total   = fault_cnt_q;

	a_frame_valid_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> frame_valid_q[$past(k)] && rank_q[$past(k)] == '0)
		else $error("updated frame not valid and most recent");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && hit_q |=> !res_fault_q && !res_ev_valid_q &&
		                        fault_cnt_q == $past(fault_cnt_q))
		else $error("hit reported a fault or an eviction");

	a_evict_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && evict |-> (frame_valid_q | ~active) == '1)
		else $error("eviction while a free frame was available");

endmodule

// ===== rtl/lru_page_replacement_top.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement_top : LRU page replacement unit
// Frame table with least recently used replacement and a fault counter.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A hit or a miss
// that fills a free frame goes through lookup and table update, then the
// result is shown for one cycle with done high while busy is already low.
// A miss with all active frames full adds the pairwise reduction over the
// recency ranks that picks the victim. done lasts one cycle and the
// receiver cannot stall it; fault_total holds its value until the next
// result. frames_in_use is meant to be set right after reset while idle.
module lru_page_replacement_top #(
	parameter int unsigned FRAMES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [lru_pkg::PAGE_W-1:0]    page_number,
	output logic                          done,
	output logic                          fault,
	output logic [lru_pkg::FIDX_W-1:0]    frame_index,
	output logic                          evicted_valid,
	output logic [lru_pkg::PAGE_W-1:0]    evicted_page,
	output logic [lru_pkg::FCNT_W-1:0]    fault_total,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [lru_pkg::REG_W-1:0]     pwdata,
	output logic [lru_pkg::REG_W-1:0]     prdata,
	output logic                          pready
);

	lru_pkg::cmd_t             cmd;
	lru_pkg::status_t          st;
	logic [lru_pkg::FIU_W-1:0] frames_in_use;

	lru_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.frames_in_use (frames_in_use)
	);

	lru_ctrl #(
		.LEV ($clog2(FRAMES))
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	lru_dp #(
		.FRAMES (FRAMES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.page_number   (page_number),
		.frames_in_use (frames_in_use),
		.fault         (fault),
		.frame_index   (frame_index),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.fault_total   (fault_total)
	);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench : LRU page replacement unit
// Page references go in through the start/busy port and frame counts through
// the APB port. A local frame table with recency ranks predicts every
// outcome, and each done pulse is checked field by field against it.
// ---------------------------------------------------------------------------
module testbench;

	localparam int unsigned TB_FRAMES        = 16;
	localparam logic [2:0]  FIU_ADDR         = {lru_pkg::REG_FRAMES_IN_USE, 2'b00};
	localparam int unsigned STALL_LIMIT      = 400;
	localparam int unsigned MAX_REPORTS      = 10;
	localparam int unsigned NUM_PHASES       = 12;
	localparam int unsigned REFS_PER_PHASE   = 54;
	localparam int unsigned POOL_DEPTH       = 40;
	localparam int unsigned FIU_PLAN [NUM_PHASES] =
		'{16, 1, 3, 8, 17, 5, 0, 16, 12, 2, 31, 6};

	typedef struct {
		logic                         fault;
		logic [lru_pkg::FIDX_W-1:0]   frame;
		logic                         ev_valid;
		logic [lru_pkg::PAGE_W-1:0]   ev_page;
		logic [lru_pkg::FCNT_W-1:0]   total;
	} outcome_t;

	class lru_tracker;
		logic [lru_pkg::PAGE_W-1:0] page_tab [TB_FRAMES];
		logic                       valid_tab [TB_FRAMES];
		int unsigned                rank_tab [TB_FRAMES];
		logic [lru_pkg::FCNT_W-1:0] faults;
		logic [lru_pkg::FIU_W-1:0]  frames_cfg;
		outcome_t                   expected_q [$];
		int unsigned                errors;

		function new();
			int i;
			for (i = 0; i < TB_FRAMES; i++) begin
				page_tab[i]  = '0;
				valid_tab[i] = 1'b0;
				rank_tab[i]  = 0;
			end
			faults     = '0;
			frames_cfg = lru_pkg::FIU_RESET;
			errors     = 0;
		endfunction

		function void set_frames(logic [lru_pkg::FIU_W-1:0] v);
			frames_cfg = v;
		endfunction

		function int unsigned active_count();
			if (frames_cfg == 0)
				return 1;
			if (frames_cfg > TB_FRAMES)
				return TB_FRAMES;
			return frames_cfg;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// frame k becomes most recent; only frames younger than old_rank age
		function void promote(int unsigned k, int unsigned n, int unsigned old_rank);
			int unsigned i;
			for (i = 0; i < n; i++) begin
				if (i != k && valid_tab[i] && rank_tab[i] < old_rank &&
				    rank_tab[i] < TB_FRAMES - 1)
					rank_tab[i]++;
			end
			rank_tab[k] = 0;
		endfunction

		function void note_reference(logic [lru_pkg::PAGE_W-1:0] pg);
			int unsigned n, k, i, best;
			bit          found;
			outcome_t    o;
			n        = active_count();
			k        = 0;
			found    = 1'b0;
			o.fault    = 1'b0;
			o.ev_valid = 1'b0;
			o.ev_page  = '0;
			for (i = 0; i < n; i++) begin
				if (valid_tab[i] && page_tab[i] == pg) begin
					k     = i;
					found = 1'b1;
					break;
				end
			end
			if (found) begin
				promote(k, n, rank_tab[k]);
			end else begin
				o.fault = 1'b1;
				if (faults != lru_pkg::FCNT_MAX)
					faults++;
				for (i = 0; i < n; i++) begin
					if (!valid_tab[i]) begin
						k     = i;
						found = 1'b1;
						break;
					end
				end
				if (found) begin
					page_tab[k]  = pg;
					valid_tab[k] = 1'b1;
					// a fresh frame ages every other valid active frame
					promote(k, n, 256);
				end else begin
					best = 0;
					k    = 0;
					for (i = 0; i < n; i++) begin
						if (rank_tab[i] > best || i == 0) begin
							best = rank_tab[i];
							k    = i;
						end
					end
					o.ev_valid  = 1'b1;
					o.ev_page   = page_tab[k];
					page_tab[k] = pg;
					promote(k, n, best);
				end
			end
			o.frame = lru_pkg::FIDX_W'(k);
			o.total = faults;
			expected_q.push_back(o);
		endfunction

		function void flag(string what, logic [31:0] want, logic [31:0] got);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
		endfunction

		function void check_outcome(outcome_t got);
			outcome_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: result with no request outstanding", $time);
				return;
			end
			want = expected_q.pop_front();
			if (got.fault !== want.fault)
				flag("fault", 32'(want.fault), 32'(got.fault));
			if (got.frame !== want.frame)
				flag("frame_index", 32'(want.frame), 32'(got.frame));
			if (got.ev_valid !== want.ev_valid)
				flag("evicted_valid", 32'(want.ev_valid), 32'(got.ev_valid));
			if (got.ev_page !== want.ev_page)
				flag("evicted_page", 32'(want.ev_page), 32'(got.ev_page));
			if (got.total !== want.total)
				flag("fault_total", want.total, got.total);
		endfunction

		function void check_drained();
			if (expected_q.size() != 0) begin
				errors += expected_q.size();
				$display("%0t: %0d requests never answered", $time, expected_q.size());
			end
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic [lru_pkg::PAGE_W-1:0]   page_number;
	logic                         done;
	logic                         fault;
	logic [lru_pkg::FIDX_W-1:0]   frame_index;
	logic                         evicted_valid;
	logic [lru_pkg::PAGE_W-1:0]   evicted_page;
	logic [lru_pkg::FCNT_W-1:0]   fault_total;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [2:0]                   paddr;
	logic [lru_pkg::REG_W-1:0]    pwdata;
	logic [lru_pkg::REG_W-1:0]    prdata;
	logic                         pready;

	lru_tracker  tracker = new();
	int unsigned quiet_cycles = 0;

	lru_page_replacement_top #(
		.FRAMES(TB_FRAMES)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.page_number   (page_number),
		.done          (done),
		.fault         (fault),
		.frame_index   (frame_index),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.fault_total   (fault_total),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		outcome_t seen;
		if (arst_n === 1'b1 && done === 1'b1) begin
			seen.fault    = fault;
			seen.frame    = frame_index;
			seen.ev_valid = evicted_valid;
			seen.ev_page  = evicted_page;
			seen.total    = fault_total;
			tracker.check_outcome(seen);
		end
	end

	// no request taken and no result seen for too long
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: watchdog expired after %0d quiet cycles", $time, quiet_cycles);
			$display("FAIL lru_page_replacement_top");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_frames(input logic [lru_pkg::FIU_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= FIU_ADDR;
		pwdata  <= lru_pkg::REG_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tracker.set_frames(v);
	endtask

	// start stays high between back-to-back requests
	task automatic send_reference(input logic [lru_pkg::PAGE_W-1:0] pg,
	                              input int unsigned idle_pct);
		int unsigned gap;
		start       <= 1'b1;
		page_number <= pg;
		do @(posedge clk); while (busy !== 1'b0);
		tracker.note_reference(pg);
		if ($urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 6);
			start       <= 1'b0;
			page_number <= lru_pkg::PAGE_W'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		logic [lru_pkg::PAGE_W-1:0] pool [POOL_DEPTH];
		logic [lru_pkg::PAGE_W-1:0] pg;
		int unsigned                p, i, j, pool_n, n_eff, idle_pct;

		arst_n      <= 1'b0;
		start       <= 1'b0;
		page_number <= '0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		for (i = 0; i < POOL_DEPTH; i++)
			pool[i] = lru_pkg::PAGE_W'($urandom);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset frame count: extremes of the page field, hits and misses
		send_reference(16'h0000, 0);
		send_reference(16'hFFFF, 0);
		send_reference(16'h0000, 0);
		send_reference(16'h5555, 0);
		send_reference(16'hAAAA, 0);
		send_reference(16'hFFFF, 0);
		drain();

		// zero frames acts as one, frames above keep their pages
		write_frames(5'd0);
		send_reference(16'h1234, 0);
		send_reference(16'h1234, 0);
		send_reference(16'h0001, 0);
		drain();

		// page 0xAAAA still sits in frame 3, outside the active range
		write_frames(5'd2);
		send_reference(16'hAAAA, 0);
		send_reference(16'hAAAA, 0);
		drain();

		// growing again leaves two copies: lowest index must hit
		write_frames(5'd4);
		send_reference(16'hAAAA, 0);
		send_reference(16'h8000, 0);
		send_reference(16'h7FFF, 0);
		send_reference(16'h0F0F, 0);
		drain();

		// above the frame count acts as all frames
		write_frames(5'd31);
		send_reference(16'h00FF, 0);
		send_reference(16'hFF00, 0);
		send_reference(16'h5555, 0);
		drain();

		for (p = 0; p < NUM_PHASES; p++) begin
			write_frames(lru_pkg::FIU_W'(FIU_PLAN[p]));
			n_eff  = tracker.active_count();
			pool_n = n_eff + $urandom_range(1, n_eff + 2);
			// keep about half the pool so pages carry across frame counts
			for (i = 0; i < pool_n; i++)
				if ($urandom_range(1) == 1)
					pool[i] = lru_pkg::PAGE_W'($urandom);
			case (p % 4)
				1: idle_pct = 45;
				3: idle_pct = 26;
				default: idle_pct = 0;
			endcase
			for (j = 0; j < REFS_PER_PHASE; j++) begin
				if ($urandom_range(99) < 80)
					pg = pool[$urandom_range(pool_n - 1)];
				else
					pg = lru_pkg::PAGE_W'($urandom);
				send_reference(pg, idle_pct);
			end
			drain();
		end

		tracker.check_drained();
		if (tracker.errors == 0)
			$display("PASS lru_page_replacement_top");
		else
			$display("FAIL lru_page_replacement_top");
		$finish;
	end

endmodule
